// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the compensation RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define STHC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sthc assertion failed");

// Property checked on every clock edge, reset included.
`define STHC_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("sthc assertion failed");

`endif

// ===== rtl/core/sthc_pkg.sv =====
// Types and constants of the temperature and humidity compensation unit.
package sthc_pkg;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_T1  = 3'd0,
    REG_T2  = 3'd1,
    REG_T3  = 3'd2,
    REG_H1  = 3'd3,
    REG_H2  = 3'd4,
    REG_H3  = 3'd5,
    REG_H45 = 3'd6,
    REG_H6  = 3'd7
  } reg_idx_t;

  localparam int CFG_DW = 24;

  // One input beat.
  typedef struct packed {
    logic [19:0] raw_temperature;
    logic [15:0] raw_humidity;
  } in_beat_t;

  // One result beat.
  typedef struct packed {
    logic signed [15:0] temperature_q8;
    logic [16:0]        humidity_q10;
  } out_beat_t;

  // Unpacked calibration coefficients.
  typedef struct packed {
    logic [15:0]        t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic [7:0]         h1;
    logic signed [15:0] h2;
    logic [7:0]         h3;
    logic signed [11:0] h4;
    logic signed [11:0] h5;
    logic signed [7:0]  h6;
  } coef_t;

endpackage

// ===== rtl/core/sensor_temp_humidity_compensation_unit.sv =====
// Top level: pipelined temperature and humidity compensation.
//
// Input channel in_valid/in_stall/in_data carries one beat of raw temperature
// and raw humidity. Output channel out_valid/out_stall/out_data returns one
// beat per input: temperature in signed 1/256 degC (saturated) and humidity
// in 1/1024 %RH clamped to 0..100 %. Calibration coefficients are written
// through cfg_we/cfg_index/cfg_wdata; the user must write them only while no
// beat is in flight, which the block does not enforce. The datapath is an
// 18-stage pipeline with at most one multiplier level per stage. A beat
// accepted into stage 1 passes through the stage registers in order before its
// result shows on out_data. One beat enters per cycle while in_stall is low.
// Each stage advances when it is empty or its successor advances, so bubbles
// close up and a stall on out_stall fills the pipe before in_stall rises; no
// beat is lost or repeated. Synchronous reset empties the pipeline and
// clears all coefficients to zero.
`include "assert_macros.svh"

module sensor_temp_humidity_compensation_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  sthc_pkg::in_beat_t          in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output sthc_pkg::out_beat_t         out_data,
  input  logic                        cfg_we,
  input  logic [2:0]                  cfg_index,
  input  logic [sthc_pkg::CFG_DW-1:0] cfg_wdata
);
  import sthc_pkg::*;

  localparam int NST = 18;
  localparam logic signed [57:0] T_RND  = 58'sd171798691840;  // 10 * 2^34
  localparam logic signed [21:0] T_HI   = 22'sd163839;
  localparam logic signed [21:0] T_LO   = -22'sd163840;
  localparam logic [18:0]        RECIP5 = 19'd419431;
  localparam logic signed [59:0] V_MIN  = -60'sd16777216;
  localparam logic signed [59:0] V_MAX  = 60'sd17592186044416;
  localparam logic signed [55:0] HUM_TOP = 56'sd1677721600;

  coef_t c;
  sthc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .coef      (c)
  );

  // Stage control.
  logic [NST:1] vld_r;
  logic [NST:1] adv;

  always_comb begin
    adv[NST] = !vld_r[NST] || !out_stall;
    for (int k = NST - 1; k >= 1; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
  end

  assign in_stall  = !adv[1];
  assign out_valid = vld_r[NST];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[1]) vld_r[1] <= in_valid;
      for (int k = 2; k <= NST; k++) begin
        if (adv[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  // Payload registers.
  logic [15:0]        adch_r [1:6];
  logic signed [20:0] d_r;
  logic signed [36:0] plin2_r, plin3_r;
  logic signed [41:0] psq_r;
  logic signed [57:0] pq_r, s_r;
  logic signed [21:0] tround_r;
  logic signed [23:0] h_r [5:6];
  logic [18:0]        n_r;
  logic               sat_hi_r [6:7];
  logic               sat_lo_r [6:7];
  logic signed [35:0] hx5_r;
  logic signed [32:0] ah_r, a_r;
  logic [39:0]        tprod_r;
  logic signed [35:0] x_r [7:11];
  logic signed [31:0] h6h_r;
  logic signed [15:0] tq_r [8:NST];
  logic signed [63:0] ha_r, b_r;
  logic signed [48:0] gl_r, gh_r;
  logic signed [44:0] g_r;
  logic signed [58:0] xl_r, xh_r;
  logic signed [45:0] vc_r [13:16];
  logic [45:0]        mhh_r;
  logic [44:0]        mhl_r;
  logic [43:0]        mll_r;
  logic [46:0]        w_r;
  logic [54:0]        hw_r;
  logic signed [55:0] v2_r;
  logic [16:0]        hq_r;

  // Combinational values of the stages.
  logic signed [21:0] dw;
  logic signed [36:0] plin_nxt;
  logic signed [41:0] psq_nxt;
  logic signed [57:0] pq_nxt, s_nxt, srnd;
  logic signed [23:0] tfine;
  logic signed [24:0] hw25;
  logic signed [21:0] nw;
  logic signed [35:0] hx5_nxt;
  logic signed [32:0] ah_nxt;
  logic [39:0]        tprod_nxt;
  logic signed [36:0] xw;
  logic signed [31:0] h6h_nxt;
  logic [15:0]        tq_u;
  logic signed [15:0] tq_nxt;
  logic signed [64:0] ha_nxt;
  logic signed [48:0] gl_nxt, gh_nxt, gsum;
  logic signed [58:0] xl_nxt, xh_nxt;
  logic signed [59:0] vsum;
  logic signed [45:0] vc_nxt;
  logic [44:0]        mag;
  logic [45:0]        mhh_nxt;
  logic [44:0]        mhl_nxt;
  logic [43:0]        mll_nxt;
  logic [68:0]        wlow;
  logic [46:0]        w_nxt;
  logic [54:0]        hw_nxt;
  logic signed [55:0] v2_nxt;
  logic [31:0]        hrnd;
  logic [16:0]        hq_nxt;

  always_comb begin
    // Stage 1: offset of the raw temperature.
    dw = $signed({2'b00, in_data.raw_temperature}) - $signed({2'b00, c.t1, 4'b0000});
    // Stage 2: linear product and square.
    plin_nxt = d_r * c.t2;
    psq_nxt  = 42'(d_r) * 42'(d_r);
    // Stage 3: quadratic term.
    pq_nxt = psq_r * c.t3;
    // Stage 4: fine temperature numerator.
    s_nxt = $signed({plin3_r, 20'd0}) + pq_r;
    // Stage 5: rounded temperature over 4, and fine temperature toward zero.
    srnd  = s_r + T_RND;
    tfine = s_r[57:34] + 24'(s_r[57] && (|s_r[33:0]));
    hw25  = 25'(tfine) - 25'sd76800;
    // Stage 6: saturation window and humidity products of the fine temperature.
    nw      = tround_r - T_LO;
    hx5_nxt = 36'(c.h5) * 36'(h_r[5]);
    ah_nxt  = $signed({1'b0, c.h3}) * 33'(h_r[5]);
    // Stage 7: divide by 5 through the reciprocal, offset term X, gain term A.
    tprod_nxt = 40'(n_r) * 40'(RECIP5);
    xw = $signed({7'd0, adch_r[6], 14'd0}) - $signed({{5{c.h4[11]}}, c.h4, 20'd0})
         - 37'(hx5_r);
    h6h_nxt = 32'(c.h6) * 32'(h_r[6]);
    // Stage 8: final temperature, first half of B.
    tq_u = tprod_r[36:21];
    if (sat_hi_r[7])      tq_nxt = 16'sh7fff;
    else if (sat_lo_r[7]) tq_nxt = -16'sh8000;
    else                  tq_nxt = $signed({~tq_u[15], tq_u[14:0]});
    ha_nxt = 65'(h6h_r) * 65'(a_r);
    // Stage 10: gain as two partial products.
    gl_nxt = 49'(c.h2) * $signed({17'd0, b_r[31:0]});
    gh_nxt = 49'(c.h2) * 49'($signed(b_r[63:32]));
    // Stage 11: combine the gain partial products.
    gsum = gh_r + (gl_r >>> 32);
    // Stage 12: X times G as two partial products.
    xl_nxt = 59'(x_r[11]) * $signed({37'd0, g_r[21:0]});
    xh_nxt = 59'(x_r[11]) * 59'($signed(g_r[44:22]));
    // Stage 13: humidity before self-correction, limited.
    vsum = 60'(xh_r) + 60'(xl_r >>> 22);
    if (vsum < V_MIN)      vc_nxt = V_MIN[45:0];
    else if (vsum > V_MAX) vc_nxt = V_MAX[45:0];
    else                   vc_nxt = vsum[45:0];
    // Stage 14: square of the magnitude in three partial products.
    mag     = vc_r[13][45] ? 45'(-vc_r[13]) : vc_r[13][44:0];
    mhh_nxt = 46'(mag[44:22]) * 46'(mag[44:22]);
    mhl_nxt = 45'(mag[44:22]) * 45'(mag[21:0]);
    mll_nxt = 44'(mag[21:0]) * 44'(mag[21:0]);
    // Stage 15: sum of the partial products scaled down by 2^43.
    wlow  = {1'b0, mhl_r, 23'd0} + 69'(mll_r);
    w_nxt = {mhh_r, 1'b0} + 47'(wlow[68:43]);
    // Stage 16: self-correction product.
    hw_nxt = 55'(c.h1) * 55'(w_r);
    // Stage 17: humidity after self-correction.
    v2_nxt = 56'(vc_r[16]) - $signed({1'b0, hw_r});
    // Stage 18: clamp and round the humidity.
    hrnd = 32'(v2_r[30:0]) + 32'd8192;
    if (v2_r <= 56'sd0)         hq_nxt = '0;
    else if (v2_r >= HUM_TOP)   hq_nxt = 17'd102400;
    else                        hq_nxt = hrnd[30:14];
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      d_r       <= dw[20:0];
      adch_r[1] <= in_data.raw_humidity;
    end
    if (adv[2]) begin
      plin2_r   <= plin_nxt;
      psq_r     <= psq_nxt;
      adch_r[2] <= adch_r[1];
    end
    if (adv[3]) begin
      pq_r      <= pq_nxt;
      plin3_r   <= plin2_r;
      adch_r[3] <= adch_r[2];
    end
    if (adv[4]) begin
      s_r       <= s_nxt;
      adch_r[4] <= adch_r[3];
    end
    if (adv[5]) begin
      tround_r  <= srnd[57:36];
      h_r[5]    <= hw25[23:0];
      adch_r[5] <= adch_r[4];
    end
    if (adv[6]) begin
      sat_hi_r[6] <= tround_r > T_HI;
      sat_lo_r[6] <= tround_r < T_LO;
      n_r         <= nw[18:0];
      hx5_r       <= hx5_nxt;
      ah_r        <= ah_nxt;
      h_r[6]      <= h_r[5];
      adch_r[6]   <= adch_r[5];
    end
    if (adv[7]) begin
      tprod_r     <= tprod_nxt;
      x_r[7]      <= xw[35:0];
      a_r         <= ah_r + 33'sd67108864;
      h6h_r       <= h6h_nxt;
      sat_hi_r[7] <= sat_hi_r[6];
      sat_lo_r[7] <= sat_lo_r[6];
    end
    if (adv[8]) begin
      tq_r[8] <= tq_nxt;
      ha_r    <= ha_nxt[63:0];
      x_r[8]  <= x_r[7];
    end
    if (adv[9]) begin
      b_r     <= ha_r + 64'sd4503599627370496;
      tq_r[9] <= tq_r[8];
      x_r[9]  <= x_r[8];
    end
    if (adv[10]) begin
      gl_r     <= gl_nxt;
      gh_r     <= gh_nxt;
      tq_r[10] <= tq_r[9];
      x_r[10]  <= x_r[9];
    end
    if (adv[11]) begin
      g_r      <= gsum[48:4];
      tq_r[11] <= tq_r[10];
      x_r[11]  <= x_r[10];
    end
    if (adv[12]) begin
      xl_r     <= xl_nxt;
      xh_r     <= xh_nxt;
      tq_r[12] <= tq_r[11];
    end
    if (adv[13]) begin
      vc_r[13] <= vc_nxt;
      tq_r[13] <= tq_r[12];
    end
    if (adv[14]) begin
      mhh_r    <= mhh_nxt;
      mhl_r    <= mhl_nxt;
      mll_r    <= mll_nxt;
      vc_r[14] <= vc_r[13];
      tq_r[14] <= tq_r[13];
    end
    if (adv[15]) begin
      w_r      <= w_nxt;
      tq_r[15] <= tq_r[14];
      vc_r[15] <= vc_r[14];
    end
    if (adv[16]) begin
      hw_r     <= hw_nxt;
      tq_r[16] <= tq_r[15];
      vc_r[16] <= vc_r[15];
    end
    if (adv[17]) begin
      v2_r     <= v2_nxt;
      tq_r[17] <= tq_r[16];
    end
    if (adv[NST]) begin
      tq_r[NST] <= tq_r[17];
      hq_r      <= hq_nxt;
    end
  end

  assign out_data.temperature_q8 = tq_r[NST];
  assign out_data.humidity_q10   = hq_r;

  `STHC_ASSERT(a_full_when_stalled, in_stall |-> (&vld_r))
  `STHC_ASSERT(a_out_held, (out_valid && out_stall) |=> out_valid)
  `STHC_ASSERT(a_hum_range, out_valid |-> (out_data.humidity_q10 <= 17'd102400))
  `STHC_ASSERT_ALWAYS(a_reset_empties, !rst_n |=> !out_valid)

endmodule

// ===== rtl/core/sthc_cfg.sv =====
// Calibration register file with unpacking of the packed humidity coefficients.
module sthc_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [2:0]                 cfg_index,
  input  logic [sthc_pkg::CFG_DW-1:0] cfg_wdata,
  output sthc_pkg::coef_t            coef
);
  import sthc_pkg::*;

  logic [15:0] t1_r, t2_r, t3_r, h2_r;
  logic [7:0]  h1_r, h3_r, h6_r;
  logic [23:0] h45_r;

  // Register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_r  <= '0;
      t2_r  <= '0;
      t3_r  <= '0;
      h1_r  <= '0;
      h2_r  <= '0;
      h3_r  <= '0;
      h45_r <= '0;
      h6_r  <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_T1:  t1_r  <= cfg_wdata[15:0];
        REG_T2:  t2_r  <= cfg_wdata[15:0];
        REG_T3:  t3_r  <= cfg_wdata[15:0];
        REG_H1:  h1_r  <= cfg_wdata[7:0];
        REG_H2:  h2_r  <= cfg_wdata[15:0];
        REG_H3:  h3_r  <= cfg_wdata[7:0];
        REG_H45: h45_r <= cfg_wdata;
        REG_H6:  h6_r  <= cfg_wdata[7:0];
        default: t1_r  <= t1_r;
      endcase
    end
  end

  // H4 takes the high byte and the low nibble of the middle byte; H5 the low
  // byte and the high nibble of the middle byte.
  always_comb begin
    coef.t1 = t1_r;
    coef.t2 = $signed(t2_r);
    coef.t3 = $signed(t3_r);
    coef.h1 = h1_r;
    coef.h2 = $signed(h2_r);
    coef.h3 = h3_r;
    coef.h4 = $signed({h45_r[23:16], h45_r[11:8]});
    coef.h5 = $signed({h45_r[7:0], h45_r[15:12]});
    coef.h6 = $signed(h6_r);
  end

endmodule

// ===== test/sensor_temp_humidity_compensation_unit_tb.sv =====
// Self-checking testbench of the temperature and humidity compensation unit.
`timescale 1ns / 100ps

module sensor_temp_humidity_compensation_unit_tb;
  import sthc_pkg::*;

  typedef logic signed [127:0] wide_t;

  // Holds the calibration copy, predicts compensated beats and checks results.
  class comp_scoreboard;
    out_beat_t   expected_q[$];
    logic [23:0] coef_reg[8];
    int          errors;

    function new();
      errors = 0;
      foreach (coef_reg[i]) coef_reg[i] = '0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [23:0] val);
      case (idx) inside
        REG_H1, REG_H3, REG_H6: coef_reg[idx] = val & 24'h0000FF;
        REG_H45:                coef_reg[idx] = val;
        default:                coef_reg[idx] = val & 24'h00FFFF;
      endcase
    endfunction

    // Floor of p / 2^sh, saturated to the signed 64-bit range.
    function wide_t sat_shift(wide_t p, int sh);
      wide_t q;
      q = p >>> sh;
      if (q > wide_t'(64'sh7FFF_FFFF_FFFF_FFFF)) q = wide_t'(64'sh7FFF_FFFF_FFFF_FFFF);
      if (q < -(wide_t'(1) <<< 63)) q = -(wide_t'(1) <<< 63);
      return q;
    endfunction

    function out_beat_t compensate(in_beat_t b);
      wide_t     t1, t2, t3, h1, h2, h3, h4, h5, h6, at, ah;
      wide_t     d, s, tq, tfine, h, x, a, bb, g, v, w, v2, hq, num, den;
      logic [7:0] b0, b1, b2;
      out_beat_t r;
      t1 = wide_t'(coef_reg[REG_T1][15:0]);
      t2 = wide_t'($signed(coef_reg[REG_T2][15:0]));
      t3 = wide_t'($signed(coef_reg[REG_T3][15:0]));
      h1 = wide_t'(coef_reg[REG_H1][7:0]);
      h2 = wide_t'($signed(coef_reg[REG_H2][15:0]));
      h3 = wide_t'(coef_reg[REG_H3][7:0]);
      b0 = coef_reg[REG_H45][23:16];
      b1 = coef_reg[REG_H45][15:8];
      b2 = coef_reg[REG_H45][7:0];
      h4 = wide_t'($signed({b0, b1[3:0]}));
      h5 = wide_t'($signed({b2, b1[7:4]}));
      h6 = wide_t'($signed(coef_reg[REG_H6][7:0]));
      at = wide_t'(b.raw_temperature);
      ah = wide_t'(b.raw_humidity);

      // Temperature: quadratic fine value, then rounded scaling with saturation.
      d = at - 16 * t1;
      s = ((d * t2) <<< 20) + d * d * t3;
      num = s + (wide_t'(10) <<< 34);
      den = wide_t'(20) <<< 34;
      tq = num / den;
      if ((num % den) != 0 && num < 0) tq = tq - 1;
      if (tq > 32767) tq = 32767;
      if (tq < -32768) tq = -32768;

      // Humidity: offset, gain from the fine temperature, self-correction, clamp.
      tfine = s / (wide_t'(1) <<< 34);
      h = tfine - 76800;
      x = (ah <<< 14) - (h4 <<< 20) - h5 * h;
      a = (wide_t'(1) <<< 26) + h3 * h;
      bb = (wide_t'(1) <<< 52) + h6 * h * a;
      g = sat_shift(h2 * bb, 36);
      v = sat_shift(x * g, 22);
      if (v < -(wide_t'(1) <<< 24)) v = -(wide_t'(1) <<< 24);
      if (v > (wide_t'(1) <<< 44)) v = wide_t'(1) <<< 44;
      w = sat_shift(v * v, 43);
      v2 = v - h1 * w;
      if (v2 <= 0) hq = 0;
      else if (v2 >= 100 * (wide_t'(1) <<< 24)) hq = 102400;
      else begin
        hq = (v2 + (wide_t'(1) <<< 13)) >>> 14;
        if (hq > 102400) hq = 102400;
      end

      r.temperature_q8 = tq[15:0];
      r.humidity_q10   = hq[16:0];
      return r;
    endfunction

    function void note_input(in_beat_t b);
      expected_q.push_back(compensate(b));
    endfunction

    function void check_result(out_beat_t r);
      out_beat_t e;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat t=%0d h=%0d", $time,
                 r.temperature_q8, r.humidity_q10);
        return;
      end
      e = expected_q.pop_front();
      if (r.temperature_q8 !== e.temperature_q8) begin
        errors++;
        $display("%0t: temperature_q8 expected %0d actual %0d", $time,
                 e.temperature_q8, r.temperature_q8);
      end
      if (r.humidity_q10 !== e.humidity_q10) begin
        errors++;
        $display("%0t: humidity_q10 expected %0d actual %0d", $time,
                 e.humidity_q10, r.humidity_q10);
      end
    endfunction
  endclass

  localparam int IDLE_LIMIT = 5000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_beat_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_beat_t   out_data;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [23:0] cfg_wdata = '0;

  comp_scoreboard sb = new();
  int idle_cycles = 0;
  int burst_left = 0;
  int stall_left = 0;
  bit stall_on = 1'b0;

  sensor_temp_humidity_compensation_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  // Monitor both channels and watch for a hung pipeline.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_input(in_data);
      if (out_valid && !out_stall) sb.check_result(out_data);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[sensor_temp_humidity_compensation_unit] ERROR");
        $finish;
      end
    end
  end

  // Result-side backpressure: mostly short stalls, a few long, and quiet stretches.
  always @(negedge clk) begin
    int r;
    if (stall_left == 0) begin
      stall_on = !stall_on;
      r = $urandom_range(0, 99);
      if (stall_on) stall_left = r < 75 ? $urandom_range(1, 3) :
                                 r < 95 ? $urandom_range(4, 12) : $urandom_range(20, 60);
      else stall_left = r < 20 ? $urandom_range(100, 300) : $urandom_range(1, 10);
    end
    stall_left--;
    out_stall = stall_on;
  end

  function automatic int gap_len();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) burst_left = $urandom_range(30, 80);
    if (r < 50) return 0;
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Drive one beat; called at a falling edge, returns at a falling edge.
  task automatic send_beat(in_beat_t b);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = b;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    @(negedge clk);
  endtask

  task automatic send_pair(int t, int hum);
    in_beat_t b;
    b.raw_temperature = t[19:0];
    b.raw_humidity = hum[15:0];
    send_beat(b);
  endtask

  // Let every expected beat arrive, then allow for the pipeline depth.
  task automatic drain();
    in_valid = 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (24) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [23:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic logic [23:0] pack_h45(int h4, int h5);
    logic [11:0] p4, p5;
    p4 = h4[11:0];
    p5 = h5[11:0];
    return {p4[11:4], p5[3:0], p4[3:0], p5[11:4]};
  endfunction

  task automatic load_coeffs(int t1, int t2, int t3, int h1, int h2, int h3,
                             logic [23:0] h45, int h6);
    write_reg(REG_T1, t1[23:0]);
    write_reg(REG_T2, t2[23:0]);
    write_reg(REG_T3, t3[23:0]);
    write_reg(REG_H1, h1[23:0]);
    write_reg(REG_H2, h2[23:0]);
    write_reg(REG_H3, h3[23:0]);
    write_reg(REG_H45, h45);
    write_reg(REG_H6, h6[23:0]);
  endtask

  // Calibration close to a typical part, optionally perturbed.
  task automatic load_typical(bit jitter);
    int j;
    j = int'(jitter);
    load_coeffs(27504 + j * ($urandom_range(0, 4000) - 2000),
                26435 + j * ($urandom_range(0, 2000) - 1000),
                -1000 + j * ($urandom_range(0, 1000) - 500),
                75 + j * ($urandom_range(0, 40) - 20),
                362 + j * ($urandom_range(0, 200) - 100),
                j * $urandom_range(0, 50),
                pack_h45(324 + j * ($urandom_range(0, 100) - 50), j * $urandom_range(0, 100)),
                30 + j * ($urandom_range(0, 20) - 10));
  endtask

  // Plausible readings around the calibrated zero most of the time, else raw noise.
  function automatic in_beat_t make_reading();
    in_beat_t b;
    int t;
    if ($urandom_range(0, 99) < 75) begin
      t = int'(sb.coef_reg[REG_T1][15:0]) * 16 + $urandom_range(0, 200000) - 100000;
      b.raw_temperature = t[19:0];
      b.raw_humidity = 16'($urandom_range(15000, 50000));
    end else begin
      b.raw_temperature = 20'($urandom());
      b.raw_humidity = 16'($urandom());
    end
    return b;
  endfunction

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset calibration: field extremes.
    send_pair(0, 0);
    send_pair(1048575, 65535);
    send_pair(1048575, 0);
    send_pair(0, 65535);
    drain();

    // Typical calibration: dry and saturated humidity, cold and hot extremes.
    load_typical(1'b0);
    send_pair(519888, 30000);
    send_pair(519888, 0);
    send_pair(519888, 65535);
    send_pair(27504 * 16, 25000);
    send_pair(0, 30000);
    send_pair(1048575, 30000);
    send_pair(400000, 40000);
    drain();

    // Coefficient fields at their largest values, H45 all ones.
    load_coeffs(65535, 32767, 32767, 255, 32767, 255, 24'hFFFFFF, 127);
    send_pair(0, 0);
    send_pair(1048575, 65535);
    send_pair(524288, 32768);
    drain();

    // Most negative coefficients.
    load_coeffs(0, -32768, -32768, 0, -32768, 0, pack_h45(-2048, -2048), -128);
    send_pair(0, 65535);
    send_pair(1048575, 0);
    send_pair(1048575, 65535);
    send_pair(524288, 32768);
    drain();

    // Random phases alternating near-typical and arbitrary calibration.
    for (int p = 0; p < 6; p++) begin
      if (p % 2 == 0) load_typical(1'b1);
      else load_coeffs($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                       $urandom(), 24'($urandom()), $urandom());
      for (int i = 0; i < 125; i++) begin
        if (p == 2 && i == 60) begin
          in_valid = 1'b0;
          while (sb.expected_q.size() != 0) @(posedge clk);
          @(negedge clk);
        end
        send_beat(make_reading());
      end
      drain();
    end

    if (sb.errors == 0 && sb.expected_q.size() == 0)
      $display("[sensor_temp_humidity_compensation_unit] OK");
    else
      $display("[sensor_temp_humidity_compensation_unit] ERROR");
    $finish;
  end

endmodule
